[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds at every clock edge out of reset
`define ASSERT_HOLDS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: check failed");

// cons holds in the same cycle as ante
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// cons holds in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

[rtl/lrt_pkg.sv]
`default_nettype none

package lrt_pkg;

    localparam int MAX_ENTRIES = 128;
    localparam int KEY_WIDTH   = 63;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int LIM_W       = 8;
    localparam int OCC_W       = 8;
    localparam int CMP_W       = (CNT_W > LIM_W) ? CNT_W : LIM_W;

    localparam logic [LIM_W-1:0] LIMIT_RESET = 8'd100;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_ENC,
        ST_UPD
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] key_pos;
        logic [IDX_W-1:0] rem_pos;
        logic             drop;
    } t_cell_ctl;

endpackage

`default_nettype wire

[rtl/lrt_if.sv]
`default_nettype none

interface lrt_in_if
    import lrt_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [KEY_WIDTH-1:0] song_key;

    modport source (output valid, output song_key, input ready);
    modport sink   (input valid, input song_key, output ready);
endinterface

interface lrt_out_if
    import lrt_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 was_present;
    logic                 evicted_valid;
    logic [KEY_WIDTH-1:0] evicted_key;
    logic [OCC_W-1:0]     occupancy;

    modport source (output valid, output was_present, output evicted_valid,
                    output evicted_key, output occupancy, input ready);
    modport sink   (input valid, input was_present, input evicted_valid,
                    input evicted_key, input occupancy, output ready);
endinterface

`default_nettype wire

[rtl/lru_recency_tracker_core.sv]
// Channel   Dir  Payload                                              Handshake
// i_item    in   song_key                                             valid/ready
// o_result  out  was_present, evicted_valid, evicted_key, occupancy   valid/ready
// cfg       in   i_cfg_wdata (limit_in_use)                           i_cfg_we
//
// One item passes four steps: accept, compare in every cell, encode the hit
// position, shift update across the cell row. The next item is taken as soon
// as the update is done, also while the result waits in the output register.
// The update stage stalls while a previous result is still not taken.
// Synchronous reset empties the list and sets the limit to 100; cell keys
// are not cleared.
`default_nettype none
`include "assert_macros.svh"

module lru_recency_tracker_core
    import lrt_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    lrt_in_if.sink                i_item,
    lrt_out_if.source             o_result,
    input  wire logic             i_cfg_we,
    input  wire logic [LIM_W-1:0] i_cfg_wdata
);

    t_state               r_state;
    t_state               n_state;
    logic [LIM_W-1:0]     r_limit;
    logic [CNT_W-1:0]     r_count;
    logic [KEY_WIDTH-1:0] r_key;

    logic                 r_hit;
    logic                 r_full;
    logic                 r_drop;
    logic [IDX_W-1:0]     r_key_pos;
    logic [IDX_W-1:0]     r_rem_pos;
    logic [CNT_W-1:0]     r_new_count;

    logic                 r_out_valid;
    logic                 r_was_present;
    logic                 r_ev_valid;
    logic [KEY_WIDTH-1:0] r_ev_key;
    logic [OCC_W-1:0]     r_occ;

    logic                 w_accept;
    logic                 w_cmp_en;
    logic                 w_enc_en;
    logic                 w_upd_go;
    logic                 w_out_take;

    logic [MAX_ENTRIES-1:0] w_match;
    logic [KEY_WIDTH-1:0]   w_chain [0:MAX_ENTRIES+1];
    t_cell_ctl              w_ctl;

    logic                 w_hit;
    logic                 w_full;
    logic [IDX_W-1:0]     w_pos;
    logic [IDX_W-1:0]     w_rem;
    logic [CNT_W-1:0]     w_cp;
    logic [CMP_W-1:0]     w_lim_ext;
    logic [CMP_W-1:0]     w_lim_eff;
    logic                 w_drop;
    logic [KEY_WIDTH-1:0] w_ev_key;

    function automatic logic [IDX_W-1:0] f_encode(input logic [MAX_ENTRIES-1:0] m);
        logic [IDX_W-1:0] res;
        res = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (m[i]) begin
                res = res | IDX_W'(i);
            end
        end
        return res;
    endfunction

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_item.valid) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                n_state = ST_ENC;
            end
            ST_ENC: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                if (!r_out_valid || o_result.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        i_item.ready = 1'b0;
        w_cmp_en     = 1'b0;
        w_enc_en     = 1'b0;
        w_upd_go     = 1'b0;
        case (r_state)
            ST_IDLE: i_item.ready = 1'b1;
            ST_CMP:  w_cmp_en     = 1'b1;
            ST_ENC:  w_enc_en     = 1'b1;
            ST_UPD:  w_upd_go     = !r_out_valid || o_result.ready;
            default: i_item.ready = 1'b0;
        endcase
    end

    assign w_accept   = i_item.valid && i_item.ready;
    assign w_out_take = r_out_valid && o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // cell row
    assign w_ctl.count   = r_count;
    assign w_ctl.key_pos = r_key_pos;
    assign w_ctl.rem_pos = r_rem_pos;
    assign w_ctl.drop    = r_drop;

    assign w_chain[MAX_ENTRIES]     = r_key;
    assign w_chain[MAX_ENTRIES + 1] = r_key;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        lrt_cell u_cell (
            .i_clk    (i_clk),
            .i_index  (IDX_W'(g)),
            .i_key    (r_key),
            .i_cmp_en (w_cmp_en),
            .i_upd_en (w_upd_go),
            .i_ctl    (w_ctl),
            .i_next1  (w_chain[g + 1]),
            .i_next2  (w_chain[g + 2]),
            .o_key    (w_chain[g]),
            .o_match  (w_match[g])
        );
    end

    // hit position and list bookkeeping
    assign w_hit     = |w_match;
    assign w_pos     = f_encode(w_match);
    assign w_full    = !w_hit && (r_count == CNT_W'(MAX_ENTRIES));
    assign w_rem     = w_hit ? w_pos : (w_full ? '0 : r_count[IDX_W-1:0]);
    assign w_cp      = (w_hit || w_full) ? r_count : r_count + CNT_W'(1);
    assign w_lim_ext = CMP_W'(r_limit);
    assign w_lim_eff = (w_lim_ext == '0) ? CMP_W'(1) :
                       ((w_lim_ext > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES) : w_lim_ext);
    assign w_drop    = !w_full && (CMP_W'(w_cp) > w_lim_eff);

    assign w_ev_key  = (r_drop && (r_rem_pos == '0)) ? w_chain[1] : w_chain[0];

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key <= i_item.song_key;
        end
        if (w_enc_en) begin
            r_hit       <= w_hit;
            r_full      <= w_full;
            r_drop      <= w_drop;
            r_rem_pos   <= w_rem;
            r_key_pos   <= w_drop ? IDX_W'(w_cp - CNT_W'(2)) : IDX_W'(w_cp - CNT_W'(1));
            r_new_count <= w_drop ? w_cp - CNT_W'(1) : w_cp;
        end
        if (w_upd_go) begin
            r_was_present <= r_hit;
            r_ev_valid    <= r_full || r_drop;
            r_ev_key      <= (r_full || r_drop) ? w_ev_key : '0;
            r_occ         <= OCC_W'(r_new_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (w_upd_go) begin
                r_count     <= r_new_count;
                r_out_valid <= 1'b1;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.was_present   = r_was_present;
    assign o_result.evicted_valid = r_ev_valid;
    assign o_result.evicted_key   = r_ev_key;
    assign o_result.occupancy     = r_occ;

    `ASSERT_HOLDS(a_count_max, i_clk, i_rst_n, r_count <= CNT_W'(MAX_ENTRIES))
    `ASSERT_IMPLIES(a_match_unique, i_clk, i_rst_n, r_state == ST_ENC, $onehot0(w_match))
    `ASSERT_NEXT(a_upd_loads_out, i_clk, i_rst_n, w_upd_go, r_out_valid && i_item.ready)
    `ASSERT_IMPLIES(a_hit_no_full, i_clk, i_rst_n, r_state == ST_UPD, !(r_hit && r_full))

endmodule

`default_nettype wire

[rtl/lrt_cell.sv]
`default_nettype none

module lrt_cell
    import lrt_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic [IDX_W-1:0]     i_index,
    input  wire logic [KEY_WIDTH-1:0] i_key,
    input  wire logic                 i_cmp_en,
    input  wire logic                 i_upd_en,
    input  wire t_cell_ctl            i_ctl,
    input  wire logic [KEY_WIDTH-1:0] i_next1,
    input  wire logic [KEY_WIDTH-1:0] i_next2,
    output logic [KEY_WIDTH-1:0]      o_key,
    output logic                      o_match
);

    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] n_key;
    logic                 r_match;
    logic                 w_live;
    logic [IDX_W:0]       w_idx_p1;

    assign w_live   = CNT_W'(i_index) < i_ctl.count;
    assign w_idx_p1 = {1'b0, i_index} + (IDX_W + 1)'(1);

    always_comb begin
        if (i_index == i_ctl.key_pos) begin
            n_key = i_key;
        end else if (i_ctl.drop) begin
            n_key = (w_idx_p1 >= {1'b0, i_ctl.rem_pos}) ? i_next2 : i_next1;
        end else begin
            n_key = (i_index >= i_ctl.rem_pos) ? i_next1 : r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmp_en) begin
            r_match <= w_live && (r_key == i_key);
        end
        if (i_upd_en) begin
            r_key <= n_key;
        end
    end

    assign o_key   = r_key;
    assign o_match = r_match;

endmodule

`default_nettype wire
